/* hw/rtl/qpsa_pkg.sv */
// Shared types, constants and tables of the quadrant photodiode sun angle block.
`default_nettype none
package qpsa_pkg;

  localparam int SAMPLE_WIDTH = 10;
  localparam int SUM_W        = SAMPLE_WIDTH + 2;
  localparam int FRAC_BITS    = 16;
  localparam int MAG_W        = SAMPLE_WIDTH + 19;
  localparam int HS_W         = 16 + SUM_W;
  localparam int RM_W         = 16 + MAG_W;
  localparam int DP_W         = 64;
  localparam int ANG_W        = 32;
  localparam int TRIG_W       = 33;
  localparam int CORDIC_STEPS = 22;
  localparam int STEP_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_APERTURE_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE    = 16'd256;

  localparam logic [28:0] GAIN_Q28 = 29'd442048841;
  localparam logic signed [DP_W-1:0] INV_GAIN_Q30 = 64'sd652032874;
  localparam logic signed [ANG_W-1:0] ANG_DEG90  = 32'sd9216000;
  localparam logic signed [ANG_W-1:0] ANG_DEG180 = 32'sd18432000;
  localparam logic signed [ANG_W-1:0] ANG_DEG360 = 32'sd36864000;

  // Classified item between front and back.
  typedef struct packed {
    logic [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic                    zero_sum;
    logic                    zero_off;
  } qpsa_item_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'sd4608000;
        5'd1:  v = 32'sd2720261;
        5'd2:  v = 32'sd1437311;
        5'd3:  v = 32'sd729602;
        5'd4:  v = 32'sd366217;
        5'd5:  v = 32'sd183287;
        5'd6:  v = 32'sd91666;
        5'd7:  v = 32'sd45836;
        5'd8:  v = 32'sd22918;
        5'd9:  v = 32'sd11459;
        5'd10: v = 32'sd5730;
        5'd11: v = 32'sd2865;
        5'd12: v = 32'sd1432;
        5'd13: v = 32'sd716;
        5'd14: v = 32'sd358;
        5'd15: v = 32'sd179;
        5'd16: v = 32'sd90;
        5'd17: v = 32'sd45;
        5'd18: v = 32'sd22;
        5'd19: v = 32'sd11;
        5'd20: v = 32'sd6;
        5'd21: v = 32'sd3;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/qpsa_front.sv */
// Front stage: takes diode samples, forms sum and differences, classifies the item.
`default_nettype none
module qpsa_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_a,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_b,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_c,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_d,
  input  wire logic                            fifo_full,
  output logic                                 busy,
  output logic                                 push,
  output qpsa_pkg::qpsa_item_t                 item
);
  import qpsa_pkg::*;

  logic       hold_v_r, hold_v_nxt;
  qpsa_item_t hold_r;
  qpsa_item_t cls;
  logic       load;
  logic [SUM_W-1:0] a, b, c, d;

  always_comb begin
    a = SUM_W'(in_diode_a);
    b = SUM_W'(in_diode_b);
    c = SUM_W'(in_diode_c);
    d = SUM_W'(in_diode_d);
    cls.sum      = a + b + c + d;
    cls.dx       = signed'(b + c - a - d);
    cls.dy       = signed'(a + b - c - d);
    cls.zero_sum = (cls.sum == '0);
    cls.zero_off = (cls.dx == '0) && (cls.dy == '0);
  end

  assign push = hold_v_r && !fifo_full;
  assign busy = hold_v_r && fifo_full;
  assign load = start && !busy;
  assign item = hold_r;
  assign hold_v_nxt = load || (hold_v_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    if (load) begin
      hold_r <= cls;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qpsa_fifo.sv */
// Short item queue between front and back.
`default_nettype none
module qpsa_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire qpsa_pkg::qpsa_item_t wr_item,
  input  wire logic                 pop,
  output qpsa_pkg::qpsa_item_t      rd_item,
  output logic                      full,
  output logic                      empty
);
  import qpsa_pkg::*;

  qpsa_item_t              slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]        count_r;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qpsa_back.sv */
// Back engine: shared CORDIC unit for azimuth, elevation and the direction vector.
`default_nettype none
module qpsa_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire qpsa_pkg::qpsa_item_t head,
  input  wire logic                 empty,
  input  wire logic [15:0]          aperture_scale,
  input  wire logic [15:0]          aperture_height,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [13:0]               out_elevation_centideg,
  output logic [15:0]               out_azimuth_centideg,
  output logic [12:0]               out_vector_x,
  output logic [12:0]               out_vector_y,
  output logic [10:0]               out_vector_z,
  output logic                      out_valid_res
);
  import qpsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_V1, S_MUL1, S_MUL2, S_V2, S_R1, S_R2, S_PROD, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] a;
    logic                    neg;
  } fold_t;

  state_t st_r;
  logic signed [DP_W-1:0]   x_r, y_r;
  logic signed [ANG_W-1:0]  z_r;
  logic [STEP_W-1:0]        step_r;
  logic                     neg_r, dxneg_r;
  logic [SUM_W-1:0]         sum_r;
  logic [MAG_W-1:0]         mag_r;
  logic [HS_W-1:0]          hs_r;
  logic [RM_W-1:0]          rm_r;
  logic signed [ANG_W-1:0]  theta_r, phi_r;
  logic signed [TRIG_W-1:0] cp_r, sp_r, ct_r, st_r2;
  logic signed [2*TRIG_W-1:0] px_r, py_r;
  logic signed [DP_W-1:0]   pz_r;

  // CORDIC step
  logic signed [DP_W-1:0]  xs, ys, x_n, y_n;
  logic signed [ANG_W-1:0] at, z_n;
  logic                    rot, dir, last;

  always_comb begin
    rot  = (st_r == S_R1) || (st_r == S_R2);
    xs   = x_r >>> step_r;
    ys   = y_r >>> step_r;
    at   = atan_step(step_r);
    dir  = rot ? !z_r[ANG_W-1] : !y_r[DP_W-1];
    last = (step_r == STEP_W'(CORDIC_STEPS - 1));
    if (rot) begin
      x_n = dir ? x_r - ys : x_r + ys;
      y_n = dir ? y_r + xs : y_r - xs;
      z_n = dir ? z_r - at : z_r + at;
    end else begin
      x_n = dir ? x_r + ys : x_r - ys;
      y_n = dir ? y_r - xs : y_r + xs;
      z_n = dir ? z_r + at : z_r - at;
    end
  end

  function automatic fold_t fold(input logic signed [ANG_W-1:0] ang);
    fold_t f;
    begin
      f.a   = ang;
      f.neg = 1'b0;
      if (f.a > ANG_DEG180) begin
        f.a = f.a - ANG_DEG360;
      end
      if (f.a > ANG_DEG90) begin
        f.a   = f.a - ANG_DEG180;
        f.neg = 1'b1;
      end else if (f.a < -ANG_DEG90) begin
        f.a   = f.a + ANG_DEG180;
        f.neg = 1'b1;
      end
      return f;
    end
  endfunction

  // Head classification for the start of an item
  logic                    head_dxneg, head_go;
  logic [SUM_W-1:0]        head_absdx;
  logic signed [SUM_W-1:0] head_vy;

  always_comb begin
    head_dxneg = head.dx[SUM_W-1];
    head_absdx = head_dxneg ? unsigned'(-head.dx) : unsigned'(head.dx);
    head_vy    = head_dxneg ? -head.dy : head.dy;
    head_go    = !head.zero_off && (aperture_scale != '0);
  end

  // Theta from the first pass, phi clamp from the second
  logic signed [ANG_W-1:0] theta_c, phi_c;
  fold_t                   fold_phi, fold_theta;

  always_comb begin
    theta_c = z_n + (dxneg_r ? ANG_DEG180 : '0);
    if (theta_c < 0) begin
      theta_c = theta_c + ANG_DEG360;
    end
    if (theta_c >= ANG_DEG360) begin
      theta_c = theta_c - ANG_DEG360;
    end
    phi_c = z_n;
    if (phi_c < 0) begin
      phi_c = '0;
    end
    if (phi_c > ANG_DEG90) begin
      phi_c = ANG_DEG90;
    end
    fold_phi   = fold(phi_c);
    fold_theta = fold(theta_r);
  end

  // Output scaling
  logic signed [2*TRIG_W-1:0] qx, qy;
  logic signed [DP_W-1:0]     qz;
  logic [12:0]                vx, vy;
  logic [10:0]                vz;
  logic signed [ANG_W-1:0]    el_w, az_w;
  logic [15:0]                az_c;

  always_comb begin
    qx = px_r + (66'sd2048 <<< 48) + (66'sd1 <<< 47);
    qy = py_r + (66'sd2048 <<< 48) + (66'sd1 <<< 47);
    qz = pz_r - (64'sd4096 <<< 30) + (64'sd1 <<< 29);
    if (qx < 0) begin
      vx = '0;
    end else if ((qx >>> 48) > 66'sd6144) begin
      vx = 13'd6144;
    end else begin
      vx = 13'(qx >>> 48);
    end
    if (qy < 0) begin
      vy = '0;
    end else if ((qy >>> 48) > 66'sd6144) begin
      vy = 13'd6144;
    end else begin
      vy = 13'(qy >>> 48);
    end
    if (qz < 0) begin
      vz = '0;
    end else if ((qz >>> 30) > 64'sd1024) begin
      vz = 11'd1024;
    end else begin
      vz = 11'(qz >>> 30);
    end
    el_w = (phi_r + 32'sd512) >>> 10;
    az_w = (theta_r + 32'sd512) >>> 10;
    az_c = (az_w >= 32'sd36000) ? 16'(az_w - 32'sd36000) : 16'(az_w);
  end

  assign pop = (st_r == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!empty) begin
            sum_r   <= head.sum;
            dxneg_r <= head_dxneg;
            step_r  <= '0;
            z_r     <= '0;
            if (head.zero_sum) begin
              out_strobe             <= 1'b1;
              out_elevation_centideg <= '0;
              out_azimuth_centideg   <= '0;
              out_vector_x           <= '0;
              out_vector_y           <= '0;
              out_vector_z           <= '0;
              out_valid_res          <= 1'b0;
            end else if (head_go) begin
              x_r  <= DP_W'(head_absdx) <<< FRAC_BITS;
              y_r  <= DP_W'(head_vy) <<< FRAC_BITS;
              st_r <= S_V1;
            end else begin
              // no offset or zero aperture scale: both angles are zero
              theta_r <= '0;
              phi_r   <= '0;
              x_r     <= INV_GAIN_Q30;
              y_r     <= '0;
              neg_r   <= 1'b0;
              st_r    <= S_R1;
            end
          end
        end
        S_V1: begin
          x_r    <= x_n;
          y_r    <= y_n;
          z_r    <= z_n;
          step_r <= step_r + 1'b1;
          if (last) begin
            theta_r <= theta_c;
            mag_r   <= MAG_W'(x_n);
            st_r    <= S_MUL1;
          end
        end
        S_MUL1: begin
          hs_r <= HS_W'(aperture_height) * HS_W'(sum_r);
          rm_r <= RM_W'(aperture_scale) * RM_W'(mag_r);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          x_r    <= signed'((DP_W'(hs_r) * DP_W'(GAIN_Q28)) >> (28 - FRAC_BITS));
          y_r    <= signed'(DP_W'(rm_r));
          z_r    <= '0;
          step_r <= '0;
          st_r   <= S_V2;
        end
        S_V2: begin
          x_r    <= x_n;
          y_r    <= y_n;
          z_r    <= z_n;
          step_r <= step_r + 1'b1;
          if (last) begin
            phi_r  <= phi_c;
            z_r    <= fold_phi.a;
            neg_r  <= fold_phi.neg;
            x_r    <= INV_GAIN_Q30;
            y_r    <= '0;
            step_r <= '0;
            st_r   <= S_R1;
          end
        end
        S_R1: begin
          x_r    <= x_n;
          y_r    <= y_n;
          z_r    <= z_n;
          step_r <= step_r + 1'b1;
          if (last) begin
            cp_r   <= TRIG_W'(neg_r ? -x_n : x_n);
            sp_r   <= TRIG_W'(neg_r ? -y_n : y_n);
            z_r    <= fold_theta.a;
            neg_r  <= fold_theta.neg;
            x_r    <= INV_GAIN_Q30;
            y_r    <= '0;
            step_r <= '0;
            st_r   <= S_R2;
          end
        end
        S_R2: begin
          x_r    <= x_n;
          y_r    <= y_n;
          z_r    <= z_n;
          step_r <= step_r + 1'b1;
          if (last) begin
            ct_r  <= TRIG_W'(neg_r ? -x_n : x_n);
            st_r2 <= TRIG_W'(neg_r ? -y_n : y_n);
            st_r  <= S_PROD;
          end
        end
        S_PROD: begin
          px_r <= sp_r * ct_r;
          py_r <= sp_r * st_r2;
          pz_r <= DP_W'(cp_r) * 64'sd5120;
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_strobe             <= 1'b1;
          out_elevation_centideg <= 14'(el_w);
          out_azimuth_centideg   <= az_c;
          out_vector_x           <= vx;
          out_vector_y           <= vy;
          out_vector_z           <= vz;
          out_valid_res          <= 1'b1;
          st_r                   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/quad_photodiode_sun_angle.sv */
// Top level of the quadrant photodiode sun angle block.
// An item is taken when start is high and busy is low; a four-entry queue lets the
// front take items back to back while the back engine works. The back engine runs
// one shared CORDIC unit, one item at a time, for azimuth vectoring, elevation
// vectoring and two sin/cos rotations; an item with zero diode sum skips it, one
// with zero offset or zero aperture scale runs only the rotations. Each result
// shows for one cycle on out_strobe and cannot be held off.
`default_nettype none
module quad_photodiode_sun_angle (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_a,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_b,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_c,
  input  wire logic [qpsa_pkg::SAMPLE_WIDTH-1:0] in_diode_d,
  output logic                                   out_strobe,
  output logic [13:0]                            out_elevation_centideg,
  output logic [15:0]                            out_azimuth_centideg,
  output logic [12:0]                            out_vector_x,
  output logic [12:0]                            out_vector_y,
  output logic [10:0]                            out_vector_z,
  output logic                                   out_valid_res,
  input  wire logic                              cfg_we,
  input  wire logic [qpsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qpsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qpsa_pkg::*;

  logic [CFG_DATA_W-1:0] scale_r, height_r;
  qpsa_item_t            f_item, q_item;
  logic                  push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= CFG_RESET_VALUE;
      height_r <= CFG_RESET_VALUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_APERTURE_SCALE:  scale_r  <= cfg_data;
        REG_APERTURE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qpsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_diode_a (in_diode_a),
    .in_diode_b (in_diode_b),
    .in_diode_c (in_diode_c),
    .in_diode_d (in_diode_d),
    .fifo_full  (full),
    .busy       (busy),
    .push       (push),
    .item       (f_item)
  );

  qpsa_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .full    (full),
    .empty   (empty)
  );

  qpsa_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (q_item),
    .empty                  (empty),
    .aperture_scale         (scale_r),
    .aperture_height        (height_r),
    .pop                    (pop),
    .out_strobe             (out_strobe),
    .out_elevation_centideg (out_elevation_centideg),
    .out_azimuth_centideg   (out_azimuth_centideg),
    .out_vector_x           (out_vector_x),
    .out_vector_y           (out_vector_y),
    .out_vector_z           (out_vector_z),
    .out_valid_res          (out_valid_res)
  );

  a_zero_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_elevation_centideg == '0 &&
      out_azimuth_centideg == '0 && out_vector_x == '0 && out_vector_z == '0))
    else $error("zero-sum result not cleared");

  a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_elevation_centideg <= 14'd9000 && out_azimuth_centideg < 16'd36000))
    else $error("angle out of range");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue overrun");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue underrun");

endmodule
`default_nettype wire
